[src/rfp_pkg.sv]
// -----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the rangefinder frame parser.
// -----------------------------------------------------------------------------
package rfp_pkg;

  // frame layout
  localparam int unsigned FRAME_LENGTH = 9;
  localparam int unsigned COUNT_W      = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
  localparam logic [COUNT_W-1:0] LAST_POS    = COUNT_W'(FRAME_LENGTH - 1);
  localparam logic [COUNT_W-1:0] POS_HDR1    = 4'd1;
  localparam logic [COUNT_W-1:0] POS_DIST_LO = 4'd2;
  localparam logic [COUNT_W-1:0] POS_DIST_HI = 4'd3;
  localparam logic [COUNT_W-1:0] POS_STR_LO  = 4'd4;
  localparam logic [COUNT_W-1:0] POS_STR_HI  = 4'd5;

  localparam logic [15:0] STRENGTH_SATURATED = 16'hFFFF;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTE  = 2'd0,
    CFG_MIN_STRENGTH = 2'd1
  } cfg_reg_e;

  localparam logic [7:0]  HEADER_BYTE_RST  = 8'd89;
  localparam logic [15:0] MIN_STRENGTH_RST = 16'd100;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] min_strength;
  } rfp_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       burst_end;
  } rfp_byte_t;

endpackage

[src/rfp_if.sv]
// -----------------------------------------------------------------------------
// rfp_if
// Valid/ready channels of the rangefinder frame parser: byte input, result
// output and configuration write.
// -----------------------------------------------------------------------------
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       burst_end;

  modport source (output valid, output data_byte, output burst_end, input ready);
  modport sink   (input valid, input data_byte, input burst_end, output ready);
endinterface

interface rfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic [15:0] strength;
  logic        frame_accepted;

  modport source (output valid, output distance, output strength,
                  output frame_accepted, input ready);
  modport sink   (input valid, input distance, input strength,
                  input frame_accepted, output ready);
endinterface

interface rfp_cfg_if;
  import rfp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rfp_in_stage.sv]
// -----------------------------------------------------------------------------
// rfp_in_stage
// Input register: captures one byte transaction per cycle while the frame core
// keeps taking bytes, and holds each byte until the frame core takes it.
// -----------------------------------------------------------------------------
module rfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  rfp_in_if.sink            in_if,
  input  logic              take_i,
  output logic              byte_valid_o,
  output rfp_pkg::rfp_byte_t byte_o
);
  import rfp_pkg::*;

  logic      valid_q, valid_d;
  rfp_byte_t byte_q;
  logic      load;

  // accept when empty or when the held byte leaves this cycle
  assign in_if.ready = !valid_q || take_i;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q.data_byte <= in_if.data_byte;
      byte_q.burst_end <= in_if.burst_end;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

[src/rfp_frame_core.sv]
// -----------------------------------------------------------------------------
// rfp_frame_core
// Burst accumulator and frame check: tracks count, sum, header match and the
// field bytes, judges the frame at the burst end and holds the result.
// -----------------------------------------------------------------------------
module rfp_frame_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfp_pkg::rfp_cfg_t  cfg_i,
  input  logic               byte_valid_i,
  input  rfp_pkg::rfp_byte_t byte_i,
  output logic               take_o,
  rfp_out_if.source          out_if
);
  import rfp_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         sum_q, sum_d;
  logic               hdr_ok_q, hdr_ok_d;
  logic [15:0]        dist_field_q, dist_field_d;
  logic [15:0]        str_field_q, str_field_d;
  logic [15:0]        held_dist_q, held_dist_d;
  logic [15:0]        held_str_q, held_str_d;
  logic               accepted_q, accepted_d;
  logic               out_valid_q, out_valid_d;

  logic [7:0]         b;
  logic               out_free;
  logic               frame_ok;
  logic               str_usable;

  assign b = byte_i.data_byte;

  // a burst end needs the result slot free
  assign out_free = !out_valid_q || out_if.ready;
  assign take_o   = byte_valid_i && (!byte_i.burst_end || out_free);

  // per-byte accumulation
  always_comb begin
    hdr_ok_d     = hdr_ok_q;
    dist_field_d = dist_field_q;
    str_field_d  = str_field_q;
    if (count_q <= POS_HDR1 && b != cfg_i.header_byte) begin
      hdr_ok_d = 1'b0;
    end
    case (count_q)
      POS_DIST_LO: dist_field_d = {dist_field_q[15:8], b};
      POS_DIST_HI: dist_field_d = {b, dist_field_q[7:0]};
      POS_STR_LO:  str_field_d  = {str_field_q[15:8], b};
      POS_STR_HI:  str_field_d  = {b, str_field_q[7:0]};
      default: ;
    endcase
    sum_d   = sum_q + b;
    count_d = (count_q < COUNT_MAX) ? count_q + 1'b1 : count_q;
  end

  // frame judgement at the burst end
  assign frame_ok   = (count_q == LAST_POS) && hdr_ok_d && (sum_q == b);
  assign str_usable = (str_field_d > cfg_i.min_strength) &&
                      (str_field_d != STRENGTH_SATURATED);

  always_comb begin
    held_dist_d = held_dist_q;
    held_str_d  = held_str_q;
    accepted_d  = accepted_q;
    out_valid_d = out_valid_q;
    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (take_o && byte_i.burst_end) begin
      out_valid_d = 1'b1;
      accepted_d  = frame_ok;
      if (frame_ok) begin
        held_str_d  = str_field_d;
        held_dist_d = str_usable ? dist_field_d : 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sum_q        <= '0;
      hdr_ok_q     <= 1'b1;
      dist_field_q <= '0;
      str_field_q  <= '0;
      held_dist_q  <= '0;
      held_str_q   <= '0;
      accepted_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      held_dist_q <= held_dist_d;
      held_str_q  <= held_str_d;
      accepted_q  <= accepted_d;
      out_valid_q <= out_valid_d;
      if (take_o) begin
        // clear burst state at the burst end
        if (byte_i.burst_end) begin
          count_q      <= '0;
          sum_q        <= '0;
          hdr_ok_q     <= 1'b1;
          dist_field_q <= '0;
          str_field_q  <= '0;
        end else begin
          count_q      <= count_d;
          sum_q        <= sum_d;
          hdr_ok_q     <= hdr_ok_d;
          dist_field_q <= dist_field_d;
          str_field_q  <= str_field_d;
        end
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.distance       = held_dist_q;
  assign out_if.strength       = held_str_q;
  assign out_if.frame_accepted = accepted_q;

endmodule

[src/rangefinder_frame_parser.sv]
// -----------------------------------------------------------------------------
// rangefinder_frame_parser
// Checks and decodes rangefinder serial frames, one byte per transaction.
//
//   channel  dir  payload                                 notes
//   in_if    in   data_byte[7:0], burst_end               one byte
//   out_if   out  distance[15:0], strength[15:0],         one per burst end
//                 frame_accepted
//   cfg_if   in   index[1:0], data[15:0]                  0 header, 1 min str
//
// One byte transaction per cycle while no result is stalled; a result is
// offered once its closing byte has passed the input register into the
// result register.
// Reset clears burst state, held values and the registers to 89 and 100.
// A stalled result holds the next burst-end byte in the input register, which
// then stalls the input; bytes ahead of it flow on.
// Configuration writes are always taken.
// -----------------------------------------------------------------------------
module rangefinder_frame_parser (
  input  logic   clk_i,
  input  logic   rst_ni,
  rfp_in_if.sink    in_if,
  rfp_out_if.source out_if,
  rfp_cfg_if.sink   cfg_if
);
  import rfp_pkg::*;

  rfp_cfg_t  cfg_q, cfg_d;
  logic      byte_valid;
  rfp_byte_t byte_s;
  logic      take;

  // register writes; unknown indexes are dropped
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_HEADER_BYTE:  cfg_d.header_byte  = cfg_if.data[7:0];
        CFG_MIN_STRENGTH: cfg_d.min_strength = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte  <= HEADER_BYTE_RST;
      cfg_q.min_strength <= MIN_STRENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .take_i       (take),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_s)
  );

  rfp_frame_core u_frame_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_s),
    .take_o       (take),
    .out_if       (out_if)
  );

endmodule

[src/rfp_checker.sv]
// -----------------------------------------------------------------------------
// rfp_checker
// Port-level checks of the rangefinder frame parser, bound to the top level.
// -----------------------------------------------------------------------------
module rfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] distance_i,
  input logic [15:0] strength_i,
  input logic        frame_accepted_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(distance_i) && $stable(strength_i) && $stable(frame_accepted_i))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with result path free");

  // saturated strength never keeps a distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_accepted_i && strength_i == 16'hFFFF |-> distance_i == 16'd0)
    else $error("distance kept at saturated strength");

  // a kept distance implies a nonzero strength
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && distance_i != 16'd0 |-> strength_i != 16'd0)
    else $error("distance held without strength");

endmodule

bind rangefinder_frame_parser rfp_checker u_rfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .distance_i       (out_if.distance),
  .strength_i       (out_if.strength),
  .frame_accepted_i (out_if.frame_accepted)
);

[dv/rangefinder_frame_parser_tb.sv]
// -----------------------------------------------------------------------------
// rangefinder_frame_parser_tb
// Self-checking bench for the rangefinder frame parser. Drives bursts of
// serial bytes (good frames, bad headers, bad checksums, short, long and
// saturating bursts, noise) under several register settings. A scoreboard
// predicts the held readings at every burst end and compares them with the
// result channel, while both sides of the byte path idle at random.
// -----------------------------------------------------------------------------
import rfp_pkg::*;

typedef struct packed {
  logic [15:0] distance;
  logic [15:0] strength;
  logic        frame_accepted;
} reading_t;

class reading_scoreboard;
  logic [7:0]  hdr_value;
  logic [15:0] min_str;
  logic [3:0]  pos_count;
  logic [7:0]  sum8;
  bit          hdr_ok;
  logic [15:0] dist_acc;
  logic [15:0] str_acc;
  logic [15:0] held_dist;
  logic [15:0] held_str;
  reading_t    expected_readings[$];
  int          mismatches;
  int          bytes_taken;
  int          frames_taken;
  int          frames_zeroed;
  int          bursts_rejected;
  int          reg_writes;

  function new();
    hdr_value       = HEADER_BYTE_RST;
    min_str         = MIN_STRENGTH_RST;
    held_dist       = '0;
    held_str        = '0;
    mismatches      = 0;
    bytes_taken     = 0;
    frames_taken    = 0;
    frames_zeroed   = 0;
    bursts_rejected = 0;
    reg_writes      = 0;
    clear_burst();
  endfunction

  function void clear_burst();
    pos_count = '0;
    sum8      = '0;
    hdr_ok    = 1'b1;
    dist_acc  = '0;
    str_acc   = '0;
  endfunction

  // apply a register write; spare indexes are ignored by the block
  function void set_reg(input logic [1:0] idx, input logic [15:0] value);
    reg_writes++;
    if (idx == CFG_HEADER_BYTE) hdr_value = value[7:0];
    else if (idx == CFG_MIN_STRENGTH) min_str = value;
  endfunction

  // advance the burst state by one byte; queue a reading at a burst end
  function void take_byte(input logic [7:0] value, input logic closing);
    logic [3:0] pos;
    logic [7:0] sum_prior;
    bit         good;
    reading_t   rd;
    pos       = pos_count;
    sum_prior = sum8;
    bytes_taken++;
    if (pos <= POS_HDR1 && value != hdr_value) hdr_ok = 1'b0;
    case (pos)
      POS_DIST_LO: dist_acc[7:0]  = value;
      POS_DIST_HI: dist_acc[15:8] = value;
      POS_STR_LO:  str_acc[7:0]   = value;
      POS_STR_HI:  str_acc[15:8]  = value;
      default: ;
    endcase
    sum8 = sum8 + value;
    if (pos_count != COUNT_MAX) pos_count = pos_count + 4'd1;
    if (!closing) return;

    good = (pos != COUNT_MAX) && (int'(pos) + 1 == FRAME_LENGTH) && hdr_ok &&
           (sum_prior == value);
    if (good) begin
      held_str = str_acc;
      if (str_acc > min_str && str_acc != STRENGTH_SATURATED) begin
        held_dist = dist_acc;
      end else begin
        held_dist = '0;
        frames_zeroed++;
      end
      frames_taken++;
    end else begin
      bursts_rejected++;
    end
    rd.distance       = held_dist;
    rd.strength       = held_str;
    rd.frame_accepted = good;
    expected_readings.push_back(rd);
    clear_burst();
  endfunction

  // compare one delivered reading with the oldest prediction
  function void check_reading(input reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      $display("%0t: unexpected reading: distance %0d strength %0d accepted %0b",
               $time, got.distance, got.strength, got.frame_accepted);
      mismatches++;
      return;
    end
    want = expected_readings.pop_front();
    if (got.distance !== want.distance) begin
      $display("%0t: distance mismatch: expected %0d, actual %0d",
               $time, want.distance, got.distance);
      mismatches++;
    end
    if (got.strength !== want.strength) begin
      $display("%0t: strength mismatch: expected %0d, actual %0d",
               $time, want.strength, got.strength);
      mismatches++;
    end
    if (got.frame_accepted !== want.frame_accepted) begin
      $display("%0t: frame_accepted mismatch: expected %0b, actual %0b",
               $time, want.frame_accepted, got.frame_accepted);
      mismatches++;
    end
  endfunction
endclass

module rangefinder_frame_parser_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 100;
  localparam int NUM_PHASES     = 6;

  // register indexes the block does not decode
  localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;

  logic clk_i;
  logic rst_ni;

  rfp_in_if  in_bus ();
  rfp_out_if out_bus ();
  rfp_cfg_if cfg_bus ();

  rangefinder_frame_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  reading_scoreboard sb = new();
  logic [7:0]        burst_q[$];
  bit                gaps_on   = 1'b1;
  bit                stalls_on = 1'b1;
  int                bytes_sent = 0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // observe every transaction on the three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) sb.take_byte(in_bus.data_byte, in_bus.burst_end);
      if (out_bus.valid && out_bus.ready) begin
        sb.check_reading({out_bus.distance, out_bus.strength, out_bus.frame_accepted});
      end
    end
  end

  // result side: ready with random stall bursts
  initial begin : result_sink
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("rangefinder_frame_parser verification failed");
    $finish;
  end

  // write one register and drop valid after the transaction
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one byte, optionally after an idle burst, and hold until taken
  task automatic send_byte(input logic [7:0] value, input logic closing, input bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= value;
    in_bus.burst_end <= closing;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic send_burst();
    bit quiet;
    quiet = !gaps_on || $urandom_range(0, 2) == 0;
    foreach (burst_q[i]) send_byte(burst_q[i], i == burst_q.size() - 1, quiet);
    bytes_sent += burst_q.size();
  endtask

  // wait out all pending readings, then idle for DRAIN_CYCLES
  task automatic drain();
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // build a full-length frame with a correct checksum
  function automatic void make_frame(input logic [15:0] dist_val, input logic [15:0] str,
                                     input logic [7:0] h0, input logic [7:0] h1);
    logic [7:0] csum;
    burst_q.delete();
    burst_q.push_back(h0);
    burst_q.push_back(h1);
    burst_q.push_back(dist_val[7:0]);
    burst_q.push_back(dist_val[15:8]);
    burst_q.push_back(str[7:0]);
    burst_q.push_back(str[15:8]);
    while (burst_q.size() < FRAME_LENGTH - 1) burst_q.push_back(8'($urandom));
    csum = '0;
    foreach (burst_q[i]) csum += burst_q[i];
    burst_q.push_back(csum);
  endfunction

  // random burst: mostly good frames, mixed with corrupted ones and noise
  function automatic void build_burst();
    int          kind;
    int          keep;
    logic [15:0] dist_val;
    logic [15:0] str;
    logic [7:0]  h0;
    logic [7:0]  h1;
    kind = $urandom_range(0, 99);
    h0   = sb.hdr_value;
    h1   = sb.hdr_value;
    case ($urandom_range(0, 6))
      0:       str = sb.min_str;
      1:       str = sb.min_str + 16'd1;
      2:       str = sb.min_str - 16'd1;
      3:       str = STRENGTH_SATURATED;
      4:       str = STRENGTH_SATURATED - 16'd1;
      5:       str = '0;
      default: str = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       dist_val = '0;
      1:       dist_val = 16'hFFFF;
      default: dist_val = 16'($urandom);
    endcase
    if (kind >= 60 && kind < 68) begin
      if ($urandom_range(0, 1)) h0 ^= 8'(1 << $urandom_range(0, 7));
      else h1 ^= 8'(1 << $urandom_range(0, 7));
    end
    make_frame(dist_val, str, h0, h1);
    if (kind >= 68 && kind < 76) begin
      burst_q[FRAME_LENGTH - 1] ^= 8'($urandom_range(1, 255));
    end else if (kind >= 76 && kind < 84) begin
      if ($urandom_range(0, 1)) begin
        keep = $urandom_range(0, FRAME_LENGTH - 2);
        burst_q = burst_q[0:keep];
      end else begin
        repeat ($urandom_range(1, 11)) burst_q.push_back(8'($urandom));
      end
    end else if (kind >= 84) begin
      burst_q.delete();
      repeat ($urandom_range(1, 20)) burst_q.push_back(8'($urandom));
    end
  endfunction

  initial begin : main
    int target;
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= '0;
    in_bus.burst_end  <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= '0;
    cfg_bus.data      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturated strength zeroes distance, lone byte, kept distance,
    // short burst
    make_frame(16'hFFFF, STRENGTH_SATURATED, HEADER_BYTE_RST, HEADER_BYTE_RST);
    send_burst();
    burst_q = '{8'hFF};
    send_burst();
    make_frame(16'hA55A, MIN_STRENGTH_RST + 16'd1, HEADER_BYTE_RST, HEADER_BYTE_RST);
    send_burst();
    burst_q = '{HEADER_BYTE_RST, HEADER_BYTE_RST, 8'h00, 8'h00, 8'h00, 8'h00};
    send_burst();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_HEADER_BYTE, 16'h0000);
          write_reg(CFG_MIN_STRENGTH, 16'h0000);
        end
        2: begin
          write_reg(CFG_HEADER_BYTE, {8'($urandom), 8'hFF});
          write_reg(CFG_MIN_STRENGTH, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_HEADER_BYTE, 16'($urandom));
          write_reg(CFG_MIN_STRENGTH, 16'($urandom));
          write_reg(CFG_IDX_SPARE_A, 16'($urandom));
          write_reg(CFG_IDX_SPARE_B, 16'($urandom));
        end
        4: begin
          write_reg(CFG_HEADER_BYTE, {8'($urandom), HEADER_BYTE_RST});
          write_reg(CFG_MIN_STRENGTH, 16'($urandom_range(0, 300)));
        end
        5: begin
          write_reg(CFG_MIN_STRENGTH, 16'($urandom));
          write_reg(CFG_HEADER_BYTE, 16'($urandom));
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
        default: ;
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_burst();
        send_burst();
      end
      in_bus.valid <= 1'b0;
      drain();
    end

    $display("Covered %0d bytes under %0d register writes: %0d frames taken",
             sb.bytes_taken, sb.reg_writes, sb.frames_taken);
    $display("(%0d with distance zeroed by weak or saturated strength), %0d bursts rejected",
             sb.frames_zeroed, sb.bursts_rejected);
    if (sb.mismatches == 0) begin
      $display("rangefinder_frame_parser verification clean");
    end else begin
      $display("rangefinder_frame_parser verification failed");
    end
    $finish;
  end

endmodule
